// ===== src/mfsf_pkg.sv =====
// mfsf_pkg: shared types and constants for the most frequent symbol finder
// controller state, command and status groups between controller and datapath
// no dependencies
package mfsf_pkg;

   localparam int unsigned SYMBOL_W     = 8;
   localparam int unsigned COUNT_OUT_W  = 13;
   localparam int unsigned SHARE_W      = 17;
   localparam int unsigned DIV_STEPS    = 17;
   localparam int unsigned DIV_CNT_W    = 5;
   localparam logic [SYMBOL_W-1:0] SPACE_CODE = 8'd32;

   typedef enum logic [2:0] {
      ST_COLLECT,
      ST_DRAIN,
      ST_SCAN,
      ST_SCAN_END,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic count_en;
      logic scan_start;
      logic scan_issue;
      logic div_step;
      logic div_first;
      logic load_result;
   } cmd_type;

   typedef struct packed {
      logic scan_last;
   } status_type;

endpackage

// ===== src/most_frequent_symbol_finder_top.sv =====
// most_frequent_symbol_finder_top: top level of the byte histogram argmax block
// depends on mfsf_pkg, mfsf_ctrl, mfsf_datapath (which holds mfsf_div)
//
// Bytes of a string are taken one per clock while the block collects; each byte
// updates a per-value count in a histogram memory with one read and one write
// port through a read-modify-write with forwarding. After the byte marked last
// the block stops taking bytes while it drains the final write, scans the
// histogram through its one read port, runs the bit-per-cycle divider for the
// Q1.16 share, and loads the result once the output register is free.
// The result then sits in an output register, so the next string can start
// while it waits to be taken; a new result is loaded only once the previous
// transaction has left. Bytes beyond MAX_LENGTH are dropped and flagged as
// overflow. The ignored symbol register may be written only while idle.
module most_frequent_symbol_finder_top #(
   parameter int unsigned MAX_LENGTH = 4096,
   parameter int unsigned ALPHABET   = 256
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [mfsf_pkg::SYMBOL_W-1:0]    req_symbol,
   input  logic                             req_last,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [mfsf_pkg::SYMBOL_W-1:0]    rsp_top_symbol,
   output logic [mfsf_pkg::COUNT_OUT_W-1:0] rsp_top_count,
   output logic [mfsf_pkg::COUNT_OUT_W-1:0] rsp_total_length,
   output logic [mfsf_pkg::SHARE_W-1:0]     rsp_share_q16,
   output logic                             rsp_found,
   output logic                             rsp_overflow,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [mfsf_pkg::SYMBOL_W-1:0]    csr_ignored_symbol
);
   import mfsf_pkg::*;

   cmd_type    cmd;
   status_type status;

   // the register accepts a write in any cycle
   assign csr_ready = 1'b1;

   mfsf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_last),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   mfsf_datapath #(
      .MAX_LENGTH (MAX_LENGTH),
      .ALPHABET   (ALPHABET)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_symbol         (req_symbol),
      .csr_valid          (csr_valid),
      .csr_ignored_symbol (csr_ignored_symbol),
      .rsp_top_symbol     (rsp_top_symbol),
      .rsp_top_count      (rsp_top_count),
      .rsp_total_length   (rsp_total_length),
      .rsp_share_q16      (rsp_share_q16),
      .rsp_found          (rsp_found),
      .rsp_overflow       (rsp_overflow)
   );

endmodule

// ===== src/mfsf_ctrl.sv =====
// mfsf_ctrl: sequencing state machine for collect, scan, divide and result load
// depends on mfsf_pkg; drives the datapath through cmd_type, reads status_type
module mfsf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_last,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output mfsf_pkg::cmd_type    cmd,
   input  mfsf_pkg::status_type status
);
   import mfsf_pkg::*;

   state_type              state_ff, state_in;
   logic [DIV_CNT_W-1:0]   div_cnt_ff, div_cnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   out_busy;

   assign out_busy = rsp_valid_ff && rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_COLLECT: begin
            if (req_valid && req_last) state_in = ST_DRAIN;
         end
         ST_DRAIN:    state_in = ST_SCAN;
         ST_SCAN: begin
            if (status.scan_last) state_in = ST_SCAN_END;
         end
         ST_SCAN_END: state_in = ST_DIV;
         ST_DIV: begin
            if (div_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!out_busy) state_in = ST_COLLECT;
         end
         default:     state_in = ST_COLLECT;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_COLLECT: begin
            req_stall    = 1'b0;
            cmd.count_en = req_valid;
         end
         ST_DRAIN:    cmd.scan_start = 1'b1;
         ST_SCAN:     cmd.scan_issue = 1'b1;
         ST_SCAN_END: cmd = '0;
         ST_DIV: begin
            cmd.div_step  = 1'b1;
            cmd.div_first = (div_cnt_ff == '0);
         end
         ST_DONE:     cmd.load_result = !out_busy;
         default:     cmd = '0;
      endcase
   end

   always_comb begin
      div_cnt_in = div_cnt_ff;
      if (state_ff == ST_SCAN_END) begin
         div_cnt_in = '0;
      end else if (state_ff == ST_DIV) begin
         div_cnt_in = div_cnt_ff + 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_result) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_COLLECT;
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         div_cnt_ff   <= div_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_last_goes_to_drain: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_last) |=> (state_ff == ST_DRAIN))
      else $error("last transaction did not start the drain step");

   a_load_into_free_output: assert property (@(posedge clock) disable iff (reset)
      cmd.load_result |-> !(rsp_valid_ff && rsp_stall))
      else $error("result loaded over a pending transaction");

   a_stall_unless_collecting: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_COLLECT) |-> req_stall)
      else $error("input taken outside the collect state");
`endif

endmodule

// ===== src/mfsf_div.sv =====
// mfsf_div: restoring divider, one quotient bit per step, for count*2^16/length
// depends on mfsf_pkg for the quotient width
module mfsf_div #(
   parameter int unsigned CW = 13
) (
   input  logic                         clock,
   input  logic                         step,
   input  logic                         first,
   input  logic [CW-1:0]                dividend,
   input  logic [CW-1:0]                divisor,
   output logic [mfsf_pkg::SHARE_W-1:0] quotient
);
   import mfsf_pkg::*;

   logic [CW:0]        rem_ff, rem_in;
   logic [SHARE_W-1:0] quo_ff, quo_in;
   logic [CW:0]        rem_sh;
   logic [CW:0]        div_ext;
   logic               ge;

   assign div_ext = (CW+1)'(divisor);
   // first step takes the 2^16 bit directly since count never exceeds length
   assign rem_sh  = first ? (CW+1)'(dividend) : {rem_ff[CW-1:0], 1'b0};
   assign ge      = rem_sh >= div_ext;

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      if (step) begin
         rem_in = ge ? (rem_sh - div_ext) : rem_sh;
         quo_in = {quo_ff[SHARE_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign quotient = quo_ff;

endmodule

// ===== src/mfsf_datapath.sv =====
// mfsf_datapath: histogram memory with forwarding, seen flags, argmax scan and result registers
// depends on mfsf_pkg and mfsf_div; controlled by mfsf_ctrl through cmd_type
module mfsf_datapath #(
   parameter int unsigned MAX_LENGTH = 4096,
   parameter int unsigned ALPHABET   = 256
) (
   input  logic                             clock,
   input  logic                             reset,
   input  mfsf_pkg::cmd_type                cmd,
   output mfsf_pkg::status_type             status,
   input  logic [mfsf_pkg::SYMBOL_W-1:0]    req_symbol,
   input  logic                             csr_valid,
   input  logic [mfsf_pkg::SYMBOL_W-1:0]    csr_ignored_symbol,
   output logic [mfsf_pkg::SYMBOL_W-1:0]    rsp_top_symbol,
   output logic [mfsf_pkg::COUNT_OUT_W-1:0] rsp_top_count,
   output logic [mfsf_pkg::COUNT_OUT_W-1:0] rsp_total_length,
   output logic [mfsf_pkg::SHARE_W-1:0]     rsp_share_q16,
   output logic                             rsp_found,
   output logic                             rsp_overflow
);
   import mfsf_pkg::*;

   localparam int unsigned CW = $clog2(MAX_LENGTH + 1);
   localparam int unsigned SW = $clog2(ALPHABET);
   localparam int unsigned WW = CW + SW;

   // memory word: rank above count
   logic [WW-1:0]         mem [ALPHABET];
   logic [WW-1:0]         rd_word_ff;
   logic [SW-1:0]         rd_addr_ff;
   logic                  rd_scan_ff;
   logic                  rd_en;
   logic [SW-1:0]         rd_addr;

   logic [SYMBOL_W-1:0]   ignored_ff, ignored_in;
   logic [ALPHABET-1:0]   seen_ff, seen_in;
   logic [CW-1:0]         length_ff, length_in;
   logic [SW:0]           distinct_ff, distinct_in;
   logic                  ovf_ff, ovf_in;

   logic                  s1_valid_ff;
   logic [SW-1:0]         s1_addr_ff;
   logic                  s1_first_ff;
   logic [SW-1:0]         s1_rank_ff;
   logic                  fwd_ff;
   logic [WW-1:0]         fwd_word_ff;

   logic [SW-1:0]         scan_addr_ff, scan_addr_in;
   logic                  best_found_ff, best_found_in;
   logic [SW-1:0]         best_sym_ff, best_sym_in;
   logic [CW-1:0]         best_cnt_ff, best_cnt_in;
   logic [SW-1:0]         best_rank_ff, best_rank_in;

   logic [SYMBOL_W-1:0]    top_symbol_ff;
   logic [COUNT_OUT_W-1:0] top_count_ff;
   logic [COUNT_OUT_W-1:0] total_length_ff;
   logic [SHARE_W-1:0]     share_ff;
   logic                   found_out_ff;
   logic                   overflow_out_ff;

   logic                  in_range;
   logic                  room;
   logic                  hit;
   logic [SW-1:0]         sym_addr;
   logic                  sym_first;
   logic [SW-1:0]         base_rank;
   logic [CW-1:0]         base_cnt;
   logic [WW-1:0]         wr_word;
   logic [CW-1:0]         rd_cnt;
   logic [SW-1:0]         rd_rank;
   logic                  take;
   logic [SHARE_W-1:0]    quotient;
   logic [31:0]           best_cnt_wide;
   logic [31:0]           length_wide;

   assign in_range  = {1'b0, req_symbol} < (SYMBOL_W+1)'(ALPHABET);
   assign room      = length_ff < CW'(MAX_LENGTH);
   assign sym_addr  = req_symbol[SW-1:0];
   assign hit       = cmd.count_en && room && in_range;
   assign sym_first = !seen_ff[sym_addr];

   // count update for the item read last cycle, with one-back forwarding
   always_comb begin
      if (s1_first_ff) begin
         base_rank = s1_rank_ff;
         base_cnt  = '0;
      end else if (fwd_ff) begin
         base_rank = fwd_word_ff[WW-1:CW];
         base_cnt  = fwd_word_ff[CW-1:0];
      end else begin
         base_rank = rd_word_ff[WW-1:CW];
         base_cnt  = rd_word_ff[CW-1:0];
      end
   end
   assign wr_word = {base_rank, CW'(base_cnt + 1'b1)};

   assign rd_en   = hit || cmd.scan_issue;
   assign rd_addr = cmd.scan_issue ? scan_addr_ff : sym_addr;

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         mem[s1_addr_ff] <= wr_word;
      end
      if (rd_en) begin
         rd_word_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      rd_addr_ff  <= rd_addr;
      s1_addr_ff  <= sym_addr;
      s1_first_ff <= sym_first;
      s1_rank_ff  <= distinct_ff[SW-1:0];
      fwd_ff      <= hit && s1_valid_ff && (s1_addr_ff == sym_addr);
      fwd_word_ff <= wr_word;
   end

   // string state
   always_comb begin
      seen_in     = seen_ff;
      length_in   = length_ff;
      distinct_in = distinct_ff;
      ovf_in      = ovf_ff;
      if (cmd.load_result) begin
         seen_in     = '0;
         length_in   = '0;
         distinct_in = '0;
         ovf_in      = 1'b0;
      end else if (cmd.count_en) begin
         if (room) begin
            length_in = length_ff + 1'b1;
         end else begin
            ovf_in = 1'b1;
         end
         if (hit) begin
            seen_in[sym_addr] = 1'b1;
            if (sym_first) distinct_in = distinct_ff + 1'b1;
         end
      end
   end

   assign ignored_in = csr_valid ? csr_ignored_symbol : ignored_ff;

   // argmax scan
   assign rd_cnt  = rd_word_ff[CW-1:0];
   assign rd_rank = rd_word_ff[WW-1:CW];
   assign take    = rd_scan_ff && seen_ff[rd_addr_ff] &&
                    (SYMBOL_W'(rd_addr_ff) != ignored_ff) &&
                    (!best_found_ff || (rd_cnt > best_cnt_ff) ||
                     ((rd_cnt == best_cnt_ff) && (rd_rank < best_rank_ff)));

   always_comb begin
      scan_addr_in  = scan_addr_ff;
      best_found_in = best_found_ff;
      best_sym_in   = best_sym_ff;
      best_cnt_in   = best_cnt_ff;
      best_rank_in  = best_rank_ff;
      if (cmd.scan_start) begin
         scan_addr_in  = '0;
         best_found_in = 1'b0;
         best_sym_in   = '0;
         best_cnt_in   = '0;
         best_rank_in  = '0;
      end else begin
         if (cmd.scan_issue) scan_addr_in = scan_addr_ff + 1'b1;
         if (take) begin
            best_found_in = 1'b1;
            best_sym_in   = rd_addr_ff;
            best_cnt_in   = rd_cnt;
            best_rank_in  = rd_rank;
         end
      end
   end

   assign status.scan_last = (scan_addr_ff == SW'(ALPHABET - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         ignored_ff    <= SPACE_CODE;
         seen_ff       <= '0;
         length_ff     <= '0;
         distinct_ff   <= '0;
         ovf_ff        <= 1'b0;
         s1_valid_ff   <= 1'b0;
         rd_scan_ff    <= 1'b0;
         scan_addr_ff  <= '0;
         best_found_ff <= 1'b0;
      end else begin
         ignored_ff    <= ignored_in;
         seen_ff       <= seen_in;
         length_ff     <= length_in;
         distinct_ff   <= distinct_in;
         ovf_ff        <= ovf_in;
         s1_valid_ff   <= hit;
         rd_scan_ff    <= cmd.scan_issue;
         scan_addr_ff  <= scan_addr_in;
         best_found_ff <= best_found_in;
      end
   end

   always_ff @(posedge clock) begin
      best_sym_ff  <= best_sym_in;
      best_cnt_ff  <= best_cnt_in;
      best_rank_ff <= best_rank_in;
   end

   mfsf_div #(
      .CW (CW)
   ) u_div (
      .clock    (clock),
      .step     (cmd.div_step),
      .first    (cmd.div_first),
      .dividend (best_cnt_ff),
      .divisor  (length_ff),
      .quotient (quotient)
   );

   assign best_cnt_wide = 32'(best_cnt_ff);
   assign length_wide   = 32'(length_ff);

   // result registers
   always_ff @(posedge clock) begin
      if (cmd.load_result) begin
         top_symbol_ff   <= SYMBOL_W'(best_sym_ff);
         top_count_ff    <= best_cnt_wide[COUNT_OUT_W-1:0];
         total_length_ff <= length_wide[COUNT_OUT_W-1:0];
         share_ff        <= best_found_ff ? quotient : '0;
         found_out_ff    <= best_found_ff;
         overflow_out_ff <= ovf_ff;
      end
   end

   assign rsp_top_symbol   = top_symbol_ff;
   assign rsp_top_count    = top_count_ff;
   assign rsp_total_length = total_length_ff;
   assign rsp_share_q16    = share_ff;
   assign rsp_found        = found_out_ff;
   assign rsp_overflow     = overflow_out_ff;

`ifndef SYNTHESIS
   a_no_write_during_scan: assert property (@(posedge clock) disable iff (reset)
      !(s1_valid_ff && rd_scan_ff))
      else $error("histogram write overlaps the scan");

   a_clear_after_load: assert property (@(posedge clock) disable iff (reset)
      cmd.load_result |=> ((seen_ff == '0) && (length_ff == '0) && !ovf_ff))
      else $error("string store not cleared after result");

   a_length_bounded: assert property (@(posedge clock) disable iff (reset)
      length_ff <= CW'(MAX_LENGTH))
      else $error("length counter beyond limit");
`endif

endmodule
